// ----- rtl/assert_macros.svh -----
// Assertion helper macros used by the RTL of the escape-time pixel engine.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check, disabled during reset
`define MEP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication check, disabled during reset
`define MEP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ----- rtl/mep_pkg.sv -----
// Shared constants, types and register codes of the escape-time pixel engine.
// No dependencies; imported by every other RTL file but assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

   // Iteration limit and image geometry
   localparam int MAX_ITER  = 4096;
   localparam int IMAGE_DIM = 1024;
   localparam int COORD_W   = $clog2(IMAGE_DIM);
   localparam int CNT_W     = $clog2(MAX_ITER) + 1;

   // Fixed point formats (Q4.28 registers)
   localparam int FRAC_W  = 28;
   localparam int CFG_W   = 32;
   localparam int STEP_W  = 31;
   localparam int CSR_IDX_W = 2;

   // Shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // Iterate width: c and z never wrap at this size
   localparam int Z_W  = STEP_W + COORD_W + 3;
   // Square term floor(v*v / 2^28) for |v| <= 2.0
   localparam int SQ_W = FRAC_W + 3;
   // Cross term floor(2*x*y / 2^28) for |x|,|y| <= 2.0
   localparam int XY_W = FRAC_W + 5;

   localparam logic signed [Z_W-1:0] Z_TWO     = Z_W'(2 ** (FRAC_W + 1));
   localparam logic signed [Z_W-1:0] Z_NEG_TWO = -Z_TWO;
   localparam logic [SQ_W:0]         SQ_FOUR   = (SQ_W + 1)'(2 ** (FRAC_W + 2));

   // Register reset values
   localparam logic [CFG_W-1:0]  RST_WINDOW_LEFT = CFG_W'(-64290292);
   localparam logic [CFG_W-1:0]  RST_WINDOW_TOP  = CFG_W'(177167401);
   localparam logic [STEP_W-1:0] RST_COLUMN_STEP = STEP_W'(3146);
   localparam logic [STEP_W-1:0] RST_ROW_STEP    = STEP_W'(3146);

   // Color ramp: quotient by reciprocal multiply plus one correction
   localparam int NUM_W     = 17;
   localparam int DEN_W     = 11;
   localparam int RCP_SHIFT = 24;
   localparam int RCP_W     = 18;
   localparam int QUO_W     = 8;
   localparam int REM_W     = NUM_W + 2;

   localparam logic [DEN_W-1:0] RAMP_DEN_A = DEN_W'(126);
   localparam logic [DEN_W-1:0] RAMP_DEN_B = DEN_W'(127);
   localparam logic [DEN_W-1:0] RAMP_DEN_C = DEN_W'(255);
   localparam logic [DEN_W-1:0] RAMP_DEN_D = DEN_W'(511);
   localparam logic [DEN_W-1:0] RAMP_DEN_E = DEN_W'(1023);
   localparam logic [DEN_W-1:0] RAMP_DEN_F = DEN_W'(2047);

   localparam logic [RCP_W-1:0] RAMP_RCP_A = RCP_W'((2 ** RCP_SHIFT) / 126);
   localparam logic [RCP_W-1:0] RAMP_RCP_B = RCP_W'((2 ** RCP_SHIFT) / 127);
   localparam logic [RCP_W-1:0] RAMP_RCP_C = RCP_W'((2 ** RCP_SHIFT) / 255);
   localparam logic [RCP_W-1:0] RAMP_RCP_D = RCP_W'((2 ** RCP_SHIFT) / 511);
   localparam logic [RCP_W-1:0] RAMP_RCP_E = RCP_W'((2 ** RCP_SHIFT) / 1023);
   localparam logic [RCP_W-1:0] RAMP_RCP_F = RCP_W'((2 ** RCP_SHIFT) / 2047);

   localparam logic [NUM_W-1:0] RAMP_K62 = NUM_W'(62);
   localparam logic [NUM_W-1:0] RAMP_K63 = NUM_W'(63);

   localparam logic [7:0] RAMP_OFF_RED_A = 8'd128;
   localparam logic [7:0] RAMP_OFF_RED_B = 8'd193;
   localparam logic [7:0] RAMP_OFF_GRN_C = 8'd1;
   localparam logic [7:0] RAMP_OFF_GRN_D = 8'd64;
   localparam logic [7:0] RAMP_OFF_GRN_E = 8'd128;
   localparam logic [7:0] RAMP_OFF_GRN_F = 8'd192;
   localparam logic [7:0] RAMP_FULL      = 8'd255;

   // Register index codes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEFT = 2'd0,
      CSR_WINDOW_TOP  = 2'd1,
      CSR_COLUMN_STEP = 2'd2,
      CSR_ROW_STEP    = 2'd3
   } csr_index_type;

   // Window registers as seen by the datapath
   typedef struct packed {
      logic [CFG_W-1:0]  window_left;
      logic [CFG_W-1:0]  window_top;
      logic [STEP_W-1:0] column_step;
      logic [STEP_W-1:0] row_step;
   } cfg_type;

   // Operands for the shared multiplier
   typedef struct packed {
      logic signed [MUL_W-1:0] op_a;
      logic signed [MUL_W-1:0] op_b;
   } mul_req_type;

   // Request to the color ramp
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } ramp_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
   } color_type;

endpackage

`default_nettype wire

// ----- rtl/mep_if.sv -----
// Valid/ready channel interfaces: pixel request, color response, register write.
// Depends on mep_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mep_req_if import mep_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_row;
   logic [COORD_W-1:0] pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface mep_rsp_if import mep_pkg::*;;
   logic             valid;
   logic             ready;
   logic [7:0]       red;
   logic [7:0]       green;
   logic [CNT_W-1:0] escape_count;

   modport source (output valid, output red, output green, output escape_count,
                   input ready);
   modport sink   (input valid, input red, input green, input escape_count,
                   output ready);
endinterface

interface mep_csr_if import mep_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/mep_csr.sv -----
// Window and step registers written through the register channel.
// Depends on mep_pkg and the mep_csr_if interface.
`timescale 1ns / 1ps
`default_nettype none

module mep_csr import mep_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mep_csr_if.sink    csr_bus,
   output cfg_type    cfg
);

   logic [CFG_W-1:0]  left_ff, left_in;
   logic [CFG_W-1:0]  top_ff, top_in;
   logic [STEP_W-1:0] col_step_ff, col_step_in;
   logic [STEP_W-1:0] row_step_ff, row_step_in;

   // Always take writes
   assign csr_bus.ready = 1'b1;

   // Decode the write
   always_comb begin
      left_in     = left_ff;
      top_in      = top_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_WINDOW_LEFT: left_in     = csr_bus.wdata;
            CSR_WINDOW_TOP:  top_in      = csr_bus.wdata;
            CSR_COLUMN_STEP: col_step_in = csr_bus.wdata[STEP_W-1:0];
            CSR_ROW_STEP:    row_step_in = csr_bus.wdata[STEP_W-1:0];
            default:         left_in     = left_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= RST_WINDOW_LEFT;
         top_ff      <= RST_WINDOW_TOP;
         col_step_ff <= RST_COLUMN_STEP;
         row_step_ff <= RST_ROW_STEP;
      end else begin
         left_ff     <= left_in;
         top_ff      <= top_in;
         col_step_ff <= col_step_in;
         row_step_ff <= row_step_in;
      end
   end

   assign cfg.window_left = left_ff;
   assign cfg.window_top  = top_ff;
   assign cfg.column_step = col_step_ff;
   assign cfg.row_step    = row_step_ff;

endmodule

`default_nettype wire

// ----- rtl/mep_mult.sv -----
// Shared signed 32x32 multiplier with a registered product.
// Depends on mep_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module mep_mult import mep_pkg::*; (
   input  wire logic                clock,
   input  mul_req_type              mul_req,
   output logic signed [PROD_W-1:0] mul_prod
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Full-precision signed product
   assign prod_in = $signed(mul_req.op_a) * $signed(mul_req.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/mep_ramp.sv -----
// Maps an escape count to red and green through the piecewise color ramp.
// Three stages: segment select, reciprocal multiply, remainder correction.
// Depends on mep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mep_ramp import mep_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  ramp_req_type ramp_req,
   output logic       ramp_done,
   output color_type  ramp_color
);

   logic [NUM_W-1:0] num_in, num_ff;
   logic [DEN_W-1:0] den_in, den_ff;
   logic [RCP_W-1:0] rcp_in, rcp_ff;
   logic [7:0]       off_in, off_ff;
   logic             red_sel_in, red_sel_ff;
   logic             direct_in, direct_ff;
   color_type        dcolor_in, dcolor_ff;
   logic             s1_vld_ff, s2_vld_ff, done_ff;

   logic [NUM_W+RCP_W-1:0] nm_prod;
   logic [QUO_W-1:0]       q0_in, q0_ff;
   logic [REM_W-1:0]       rem;
   logic [QUO_W-1:0]       quo;
   logic [7:0]             level;
   color_type              color_in, color_ff;

   // Pick the ramp segment for this count
   always_comb begin
      num_in     = '0;
      den_in     = RAMP_DEN_A;
      rcp_in     = RAMP_RCP_A;
      off_in     = 8'd0;
      red_sel_in = 1'b1;
      direct_in  = 1'b0;
      dcolor_in  = '0;
      priority if (ramp_req.count[CNT_W-1]) begin
         // never escaped: black
         direct_in = 1'b1;
      end else if (ramp_req.count < CNT_W'(64)) begin
         direct_in     = 1'b1;
         dcolor_in.red = {ramp_req.count[6:0], 1'b0};
      end else if (ramp_req.count < CNT_W'(128)) begin
         num_in = NUM_W'({ramp_req.count[5:0], 7'b0});
         den_in = RAMP_DEN_A;
         rcp_in = RAMP_RCP_A;
         off_in = RAMP_OFF_RED_A;
      end else if (ramp_req.count < CNT_W'(256)) begin
         num_in = NUM_W'(ramp_req.count[6:0]) * RAMP_K62;
         den_in = RAMP_DEN_B;
         rcp_in = RAMP_RCP_B;
         off_in = RAMP_OFF_RED_B;
      end else if (ramp_req.count < CNT_W'(512)) begin
         num_in     = NUM_W'(ramp_req.count[7:0]) * RAMP_K62;
         den_in     = RAMP_DEN_C;
         rcp_in     = RAMP_RCP_C;
         off_in     = RAMP_OFF_GRN_C;
         red_sel_in = 1'b0;
      end else if (ramp_req.count < CNT_W'(1024)) begin
         num_in     = NUM_W'(ramp_req.count[8:0]) * RAMP_K63;
         den_in     = RAMP_DEN_D;
         rcp_in     = RAMP_RCP_D;
         off_in     = RAMP_OFF_GRN_D;
         red_sel_in = 1'b0;
      end else if (ramp_req.count < CNT_W'(2048)) begin
         num_in     = NUM_W'(ramp_req.count[9:0]) * RAMP_K63;
         den_in     = RAMP_DEN_E;
         rcp_in     = RAMP_RCP_E;
         off_in     = RAMP_OFF_GRN_E;
         red_sel_in = 1'b0;
      end else begin
         num_in     = NUM_W'(ramp_req.count[10:0]) * RAMP_K63;
         den_in     = RAMP_DEN_F;
         rcp_in     = RAMP_RCP_F;
         off_in     = RAMP_OFF_GRN_F;
         red_sel_in = 1'b0;
      end
   end

   // Estimate the quotient; it is exact or one short
   assign nm_prod = (NUM_W + RCP_W)'(num_ff) * (NUM_W + RCP_W)'(rcp_ff);
   assign q0_in   = nm_prod[RCP_SHIFT+QUO_W-1:RCP_SHIFT];

   // Correct the estimate and assemble the color
   always_comb begin
      rem      = REM_W'(num_ff) - REM_W'(q0_ff) * REM_W'(den_ff);
      quo      = q0_ff + QUO_W'(rem >= REM_W'(den_ff));
      level    = off_ff + quo;
      color_in = '0;
      priority if (direct_ff) begin
         color_in = dcolor_ff;
      end else if (red_sel_ff) begin
         color_in.red = level;
      end else begin
         color_in.red   = RAMP_FULL;
         color_in.green = level;
      end
   end

   // Stage registers hold until the next start
   always_ff @(posedge clock) begin
      if (ramp_req.start) begin
         num_ff     <= num_in;
         den_ff     <= den_in;
         rcp_ff     <= rcp_in;
         off_ff     <= off_in;
         red_sel_ff <= red_sel_in;
         direct_ff  <= direct_in;
         dcolor_ff  <= dcolor_in;
      end
      if (s1_vld_ff) begin
         q0_ff <= q0_in;
      end
      if (s2_vld_ff) begin
         color_ff <= color_in;
      end
   end

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= ramp_req.start;
         s2_vld_ff <= s1_vld_ff;
         done_ff   <= s2_vld_ff;
      end
   end

   assign ramp_done  = done_ff;
   assign ramp_color = color_ff;

endmodule

`default_nettype wire

// ----- rtl/mep_core.sv -----
// Sequencer and iterate datapath: forms c, runs z = z*z + c on the shared
// multiplier, hands the count to the ramp and holds the response register.
// Depends on mep_pkg, the channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mep_core import mep_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   mep_req_if.sink                  req_bus,
   mep_rsp_if.source                rsp_bus,
   input  cfg_type                  cfg,
   output mul_req_type              mul_req,
   input  wire logic signed [PROD_W-1:0] mul_prod,
   output ramp_req_type             ramp_req,
   input  wire logic                ramp_done,
   input  color_type                ramp_color
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CRE   = 9'b000000010,
      ST_CIM   = 9'b000000100,
      ST_CHECK = 9'b000001000,
      ST_SQX   = 9'b000010000,
      ST_SQY   = 9'b000100000,
      ST_CROSS = 9'b001000000,
      ST_RAMP  = 9'b010000000,
      ST_HOLD  = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [Z_W-1:0]     cr_ff, cr_in;
   logic [Z_W-1:0]     ci_ff, ci_in;
   logic signed [Z_W-1:0] zr_ff, zr_in;
   logic signed [Z_W-1:0] zi_ff, zi_in;
   logic [SQ_W-1:0]    x2_ff, x2_in;
   logic [SQ_W-1:0]    y2_ff, y2_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;
   color_type          rsp_color_ff;
   logic [CNT_W-1:0]   rsp_count_ff;

   logic               req_fire;
   logic               rsp_load;
   logic               z_big;
   logic [SQ_W-1:0]    sq_term;
   logic [SQ_W:0]      mag_sum;
   logic [XY_W-1:0]    xy_term;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Pass terms taken from the registered product
   assign sq_term = mul_prod[FRAC_W+SQ_W-1:FRAC_W];
   assign xy_term = mul_prod[FRAC_W+XY_W-2:FRAC_W-1];
   assign mag_sum = {1'b0, x2_ff} + {1'b0, sq_term};
   assign z_big   = (zr_ff > Z_TWO) || (zr_ff < Z_NEG_TWO) ||
                    (zi_ff > Z_TWO) || (zi_ff < Z_NEG_TWO);

   // Sequencer and operand select
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      x2_in          = x2_ff;
      y2_in          = y2_ff;
      n_in           = n_ff;
      rsp_load       = 1'b0;
      mul_req.op_a   = zr_ff[MUL_W-1:0];
      mul_req.op_b   = zi_ff[MUL_W-1:0];
      ramp_req.start = 1'b0;
      ramp_req.count = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mul_req.op_a = {1'b0, cfg.column_step};
            mul_req.op_b = {{(MUL_W-COORD_W){1'b0}}, req_bus.pixel_col};
            if (req_fire) begin
               row_in   = req_bus.pixel_row;
               state_in = ST_CRE;
            end
         end
         ST_CRE: begin
            cr_in = {{(Z_W-CFG_W){cfg.window_left[CFG_W-1]}}, cfg.window_left} +
                    mul_prod[Z_W-1:0];
            mul_req.op_a = {1'b0, cfg.row_step};
            mul_req.op_b = {{(MUL_W-COORD_W){1'b0}}, row_ff};
            state_in     = ST_CIM;
         end
         ST_CIM: begin
            ci_in = {{(Z_W-CFG_W){cfg.window_top[CFG_W-1]}}, cfg.window_top} -
                    mul_prod[Z_W-1:0];
            zr_in    = '0;
            zi_in    = '0;
            n_in     = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // Issue zr*zr; the product goes unused if the pass ends here
            mul_req.op_a = zr_ff[MUL_W-1:0];
            mul_req.op_b = zr_ff[MUL_W-1:0];
            if ((n_ff == CNT_W'(MAX_ITER)) || z_big) begin
               ramp_req.start = 1'b1;
               state_in       = ST_RAMP;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            x2_in        = sq_term;
            mul_req.op_a = zi_ff[MUL_W-1:0];
            mul_req.op_b = zi_ff[MUL_W-1:0];
            state_in     = ST_SQY;
         end
         ST_SQY: begin
            y2_in = sq_term;
            if (mag_sum > SQ_FOUR) begin
               ramp_req.start = 1'b1;
               state_in       = ST_RAMP;
            end else begin
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            zr_in = {{(Z_W-SQ_W){1'b0}}, x2_ff} - {{(Z_W-SQ_W){1'b0}}, y2_ff} + cr_ff;
            zi_in = {{(Z_W-XY_W){xy_term[XY_W-1]}}, xy_term} + ci_ff;
            n_in     = n_ff + CNT_W'(1);
            state_in = ST_CHECK;
         end
         ST_RAMP: begin
            if (ramp_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // Move the result out once the response register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Load, hold or drop the response
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      x2_ff  <= x2_in;
      y2_ff  <= y2_in;
      n_ff   <= n_in;
      if (rsp_load) begin
         rsp_color_ff <= ramp_color;
         rsp_count_ff <= n_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.red          = rsp_color_ff.red;
   assign rsp_bus.green        = rsp_color_ff.green;
   assign rsp_bus.escape_count = rsp_count_ff;

   // A squared operand never comes back negative
   `MEP_ASSERT_IMP(a_square_nonneg, clock, reset, state_ff == ST_SQX, !mul_prod[PROD_W-1])
   // The pass counter never runs past the limit
   `MEP_ASSERT_IMP(a_count_limit, clock, reset, state_ff == ST_CHECK, n_ff <= CNT_W'(MAX_ITER))
   // The ramp only finishes while the sequencer waits for it
   `MEP_ASSERT_IMP(a_ramp_wait, clock, reset, ramp_done, state_ff == ST_RAMP)
   // A loaded response is offered in the next cycle
   `MEP_ASSERT_NXT(a_rsp_load, clock, reset, rsp_load, rsp_valid_ff)
   // Points that never escape come out black
   `MEP_ASSERT_IMP(a_black, clock, reset, rsp_valid_ff && (rsp_count_ff == CNT_W'(MAX_ITER)), (rsp_color_ff.red == 8'd0) && (rsp_color_ff.green == 8'd0))

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_pixel.sv -----
// Mandelbrot escape-time evaluator for one pixel per request. A request carries
// a pixel row and column; the block forms c = (window_left + column_step*col,
// window_top - row_step*row) in Q4.28, iterates z = z*z + c from zero until
// |z|^2 > 4 or 4096 passes, and answers with the escape count and the red and
// green channels of the color ramp (blue 0, alpha 255 implied). One request is
// in flight at a time; no new request is accepted until the last one's response
// is loaded. The time per pixel grows with its pass count and is set by the
// single 32x32 multiplier, which each pass uses three times (zr*zr, zi*zi,
// zr*zi) followed by an update step. Register writes are taken at any time but
// must only happen while the block is idle.
// Top level: ties the register file, sequencer, shared multiplier and ramp.
// Depends on mep_pkg, mep_if, mep_csr, mep_mult, mep_ramp and mep_core.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_pixel import mep_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mep_req_if.sink    req_bus,
   mep_rsp_if.source  rsp_bus,
   mep_csr_if.sink    csr_bus
);

   cfg_type                  cfg;
   mul_req_type              mul_req;
   logic signed [PROD_W-1:0] mul_prod;
   ramp_req_type             ramp_req;
   logic                     ramp_done;
   color_type                ramp_color;

   mep_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mep_mult u_mult (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   mep_ramp u_ramp (
      .clock      (clock),
      .reset      (reset),
      .ramp_req   (ramp_req),
      .ramp_done  (ramp_done),
      .ramp_color (ramp_color)
   );

   mep_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .cfg        (cfg),
      .mul_req    (mul_req),
      .mul_prod   (mul_prod),
      .ramp_req   (ramp_req),
      .ramp_done  (ramp_done),
      .ramp_color (ramp_color)
   );

endmodule

`default_nettype wire

// ----- test/tb_mandelbrot_escape_pixel.sv -----
// Testbench for mandelbrot_escape_pixel: drives pixel requests and register writes,
// predicts each escape count and color in its own fixed-point model, and checks responses.
// Depends on mep_pkg, mep_if and the block's RTL.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel;
   import mep_pkg::*;

   localparam int     CLK_PERIOD = 4;
   localparam int     RESET_CYCLES = 5;
   localparam int     RUN_LIMIT = 10_000_000;
   localparam int     LONG_HOLD = 40000;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     PHASE_ITEMS = 25;
   localparam int     RANDOM_PHASES = 5;
   localparam int     DEEP_COUNT = 400;
   localparam int     DEEP_BUDGET = 12;
   localparam longint Q_TWO = longint'(2) << FRAC_W;
   localparam longint Q_FOUR = longint'(4) << FRAC_W;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [CNT_W-1:0]   escape_count;
   } pixel_outcome_t;

   typedef enum logic {
      ROW_WRITE,
      ROW_PIXEL
   } table_row_kind_t;

   typedef struct {
      table_row_kind_t    kind;
      csr_index_type      reg_index;
      logic [CFG_W-1:0]   reg_value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      bit                 known;
      pixel_outcome_t     golden;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;

   mep_req_if req_bus ();
   mep_rsp_if rsp_bus ();
   mep_csr_if csr_bus ();

   mandelbrot_escape_pixel u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the window registers
   logic signed [CFG_W-1:0] win_left = RST_WINDOW_LEFT;
   logic signed [CFG_W-1:0] win_top = RST_WINDOW_TOP;
   logic [STEP_W-1:0]       col_step = RST_COLUMN_STEP;
   logic [STEP_W-1:0]       row_step_q = RST_ROW_STEP;

   pixel_outcome_t awaited_pixels[$];
   stim_row_t      directed_rows[$];
   int             failures = 0;
   bit             hold_request = 1'b0;
   bit             steady_tail = 1'b0;

   // 4 ns clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Escape-time iteration and color ramp for one pixel under the shadow registers
   function automatic pixel_outcome_t escape_color(logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col);
      longint         cr, ci, zr, zi, x2, y2, xy2;
      int             n;
      bit             escaped;
      pixel_outcome_t res;
      cr = longint'(win_left) + longint'(col_step) * longint'(col);
      ci = longint'(win_top) - longint'(row_step_q) * longint'(row);
      zr = 0;
      zi = 0;
      n = 0;
      escaped = 1'b0;
      while (!escaped && n < MAX_ITER) begin
         // skip the multiply once either part is past 2.0
         if (zr > Q_TWO || -zr > Q_TWO || zi > Q_TWO || -zi > Q_TWO) begin
            escaped = 1'b1;
         end else begin
            x2 = (zr * zr) >>> FRAC_W;
            y2 = (zi * zi) >>> FRAC_W;
            if (x2 + y2 > Q_FOUR) begin
               escaped = 1'b1;
            end else begin
               xy2 = (2 * zr * zi) >>> FRAC_W;
               zr = x2 - y2 + cr;
               zi = xy2 + ci;
               n++;
            end
         end
      end
      res.row = row;
      res.col = col;
      res.escape_count = CNT_W'(n);
      res.red = 8'd0;
      res.green = 8'd0;
      // map the count onto the piecewise ramp; never escaped stays black
      if (n < MAX_ITER) begin
         if (n < 64) begin
            res.red = 8'(n * 2);
         end else if (n < 128) begin
            res.red = 8'(((n - 64) * 128) / 126 + 128);
         end else if (n < 256) begin
            res.red = 8'(((n - 128) * 62) / 127 + 193);
         end else begin
            res.red = 8'd255;
            if (n < 512) res.green = 8'(((n - 256) * 62) / 255 + 1);
            else if (n < 1024) res.green = 8'(((n - 512) * 63) / 511 + 64);
            else if (n < 2048) res.green = 8'(((n - 1024) * 63) / 1023 + 128);
            else res.green = 8'(((n - 2048) * 63) / 2047 + 192);
         end
      end
      return res;
   endfunction

   function automatic void report_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endfunction

   // Directed table builders
   function automatic void add_write(csr_index_type idx, logic [CFG_W-1:0] value);
      stim_row_t r;
      r = '{kind: ROW_WRITE, reg_index: CSR_WINDOW_LEFT, default: '0};
      r.kind = ROW_WRITE;
      r.reg_index = idx;
      r.reg_value = value;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      stim_row_t r;
      r = '{kind: ROW_PIXEL, reg_index: CSR_WINDOW_LEFT, default: '0};
      r.kind = ROW_PIXEL;
      r.row = row;
      r.col = col;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_known(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                     logic [7:0] red, logic [7:0] green,
                                     logic [CNT_W-1:0] count);
      stim_row_t r;
      r = '{kind: ROW_PIXEL, reg_index: CSR_WINDOW_LEFT, default: '0};
      r.kind = ROW_PIXEL;
      r.row = row;
      r.col = col;
      r.known = 1'b1;
      r.golden.row = row;
      r.golden.col = col;
      r.golden.red = red;
      r.golden.green = green;
      r.golden.escape_count = count;
      directed_rows.push_back(r);
   endfunction

   // Offer one request, optionally after an idle burst, and log its expected color
   task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                             input pixel_outcome_t outcome);
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.pixel_row <= row;
      req_bus.pixel_col <= col;
      do @(posedge clock); while (!req_bus.ready);
      awaited_pixels.push_back(outcome);
   endtask

   // Drop the request and wait until every response is back
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_WINDOW_LEFT: win_left = value;
         CSR_WINDOW_TOP:  win_top = value;
         CSR_COLUMN_STEP: col_step = value[STEP_W-1:0];
         CSR_ROW_STEP:    row_step_q = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_window(input logic [CFG_W-1:0] left, input logic [CFG_W-1:0] top,
                              input logic [CFG_W-1:0] cstep, input logic [CFG_W-1:0] rstep);
      drain();
      write_register(CSR_WINDOW_LEFT, left);
      write_register(CSR_WINDOW_TOP, top);
      write_register(CSR_COLUMN_STEP, cstep);
      write_register(CSR_ROW_STEP, rstep);
   endtask

   // Response ready: random stall bursts, one long hold on request, none in the tail
   initial begin
      int burst_left;
      int hold_left;
      bit hold_taken;
      burst_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (steady_tail) begin
            rsp_bus.ready <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 16);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each response with the oldest expected color
   always @(posedge clock) begin
      pixel_outcome_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_pixels.size() == 0) begin
            report_failure($sformatf("response with no request pending: r=%0d g=%0d n=%0d",
                                     rsp_bus.red, rsp_bus.green, rsp_bus.escape_count));
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_bus.red !== want.red || rsp_bus.green !== want.green ||
                rsp_bus.escape_count !== want.escape_count) begin
               report_failure($sformatf(
                  "pixel (%0d,%0d): expected r=%0d g=%0d n=%0d, got r=%0d g=%0d n=%0d",
                  want.row, want.col, want.red, want.green, want.escape_count,
                  rsp_bus.red, rsp_bus.green, rsp_bus.escape_count));
            end
         end
      end
   end

   // Cycle limit
   initial begin
      int unsigned cycles_run;
      for (cycles_run = 0; cycles_run < RUN_LIMIT; cycles_run++) @(posedge clock);
      $display("timeout after %0d cycles", cycles_run);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      pixel_outcome_t     guess;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      int                 deep_left;
      int                 tries;
      logic [CFG_W-1:0]   left_v, top_v, cstep_v, rstep_v;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel_row = '0;
      req_bus.pixel_col = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_WINDOW_LEFT;
      csr_bus.wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset window
      add_pixel(10'd0, 10'd0);
      add_pixel(10'd1023, 10'd1023);
      add_pixel(10'd511, 10'd512);
      // c = 0 never escapes: black
      add_write(CSR_WINDOW_LEFT, 32'd0);
      add_write(CSR_WINDOW_TOP, 32'd0);
      add_write(CSR_COLUMN_STEP, 32'd0);
      add_write(CSR_ROW_STEP, 32'd0);
      add_known(10'd1023, 10'd1023, 8'd0, 8'd0, CNT_W'(MAX_ITER));
      // Large z at the register extremes escapes after one pass
      add_write(CSR_WINDOW_LEFT, 32'h7FFF_FFFF);
      add_known(10'd5, 10'd5, 8'd2, 8'd0, CNT_W'(1));
      add_write(CSR_WINDOW_LEFT, 32'h8000_0000);
      add_known(10'd0, 10'd1023, 8'd2, 8'd0, CNT_W'(1));
      add_write(CSR_WINDOW_TOP, 32'h7FFF_FFFF);
      add_write(CSR_COLUMN_STEP, 32'h7FFF_FFFF);
      add_write(CSR_ROW_STEP, 32'h7FFF_FFFF);
      add_known(10'd1023, 10'd1023, 8'd2, 8'd0, CNT_W'(1));
      add_known(10'd0, 10'd0, 8'd2, 8'd0, CNT_W'(1));
      add_write(CSR_WINDOW_LEFT, 32'd0);
      add_write(CSR_COLUMN_STEP, 32'd0);
      add_write(CSR_ROW_STEP, 32'd0);
      add_write(CSR_WINDOW_TOP, 32'h8000_0000);
      add_known(10'd700, 10'd300, 8'd2, 8'd0, CNT_W'(1));
      // Step with bit 31 set: upper bit dropped, 0.25 per column; c = 0.5 and 2.0
      add_write(CSR_WINDOW_TOP, 32'd0);
      add_write(CSR_COLUMN_STEP, 32'h8400_0000);
      add_pixel(10'd0, 10'd2);
      add_pixel(10'd0, 10'd8);
      // Just right of the cusp at 0.25: counts climb through the upper ramp segments
      add_write(CSR_WINDOW_LEFT, 32'd67108864);
      add_write(CSR_COLUMN_STEP, 32'd268);
      add_pixel(10'd0, 10'd1000);
      add_pixel(10'd9, 10'd256);
      add_pixel(10'd0, 10'd64);
      add_pixel(10'd1023, 10'd16);
      add_pixel(10'd0, 10'd4);
      add_pixel(10'd0, 10'd1);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain();
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            guess = directed_rows[i].known ? directed_rows[i].golden :
                    escape_color(directed_rows[i].row, directed_rows[i].col);
            send_pixel(directed_rows[i].row, directed_rows[i].col, guess);
         end
      end

      // Random phases, each under its own window
      deep_left = DEEP_BUDGET;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               // full view: -2.5..1.5 by 2.0..-2.0
               left_v = 32'hD800_0000;
               top_v = 32'h2000_0000;
               cstep_v = 32'h0010_0000;
               rstep_v = 32'h0010_0000;
            end
            1: begin
               // zoom near the seahorse valley
               left_v = 32'(-204010946 + int'($urandom_range(0, 1 << 20)));
               top_v = 32'(32212255 + int'($urandom_range(0, 1 << 20)));
               cstep_v = $urandom_range(4096, 65536);
               rstep_v = $urandom_range(4096, 65536);
            end
            2: begin
               left_v = $urandom();
               top_v = $urandom();
               cstep_v = $urandom();
               rstep_v = $urandom();
            end
            3: begin
               left_v = $urandom();
               top_v = $urandom();
               cstep_v = $urandom() >> $urandom_range(8, 31);
               rstep_v = $urandom() >> $urandom_range(8, 31);
            end
            default: begin
               // offset view around the main body, no idling from here on
               left_v = 32'(-536870912 + int'($urandom_range(0, 1 << 26)));
               top_v = 32'(335544320 - int'($urandom_range(0, 1 << 26)));
               cstep_v = $urandom_range(1 << 18, 1 << 19);
               rstep_v = $urandom_range(1 << 18, 1 << 19);
            end
         endcase
         load_window(left_v, top_v, cstep_v, rstep_v);
         if (phase == RANDOM_PHASES - 1) steady_tail = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // hold off responses while requests keep coming
            if (phase == 0 && k == 3) hold_request = 1'b1;
            // redraw slow pixels once the budget for them is spent
            tries = 0;
            do begin
               row = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                                 : 10'($urandom_range(0, 1023));
               col = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                                 : 10'($urandom_range(0, 1023));
               guess = escape_color(row, col);
               tries++;
            end while (guess.escape_count > DEEP_COUNT && deep_left == 0 && tries < 64);
            if (guess.escape_count > DEEP_COUNT && deep_left > 0) deep_left--;
            send_pixel(row, col, guess);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mep_pkg.sv
rtl/mep_if.sv
rtl/mep_csr.sv
rtl/mep_mult.sv
rtl/mep_ramp.sv
rtl/mep_core.sv
rtl/mandelbrot_escape_pixel.sv
test/tb_mandelbrot_escape_pixel.sv
